// File: sv/ffha_pkg.sv
package ffha_pkg;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO     = 3'd1;
   localparam logic [2:0] ST_NOSPACE  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_UNKNOWN  = 3'd4;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_RESIZE = 2'd2;
   localparam logic [1:0] MODE_ZALLOC = 2'd3;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] request_size;
      logic [31:0] element_count;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] address;
   } rsp_type;

   // One table entry: header address, payload size and free mark.
   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
      logic        free;
   } entry_type;

endpackage

// File: sv/first_fit_heap_allocator_top.sv
// First-fit heap allocator with a break pointer.
// Requests arrive on the req_ channel (mode, request_size, element_count,
// block_address) and each gives exactly one result on the rsp_ channel
// (status, address). Configuration registers heap_base (index 0) and
// heap_limit (index 1) are written over the csr_ channel; the user must
// write them only while idle, since the block does not enforce it. The
// block table sits in one synchronous memory of MAX_BLOCKS entries, read
// one entry a cycle. An allocate scans up to entry_count entries, each
// with a read step and then a test step, and appends at the break on a
// miss; free and resize scan for the address first, and a resize that
// must move the block scans again for its new place. A zeroed allocate
// first forms its size in the multiplier. One request is in work at a
// time; req_stall is high while busy. The result waits in an output
// register while rsp_stall is high; the next request is accepted during
// that wait and its result is held back until the register is free.
// Reset clears the entry count, sets the break to the heap_base reset
// value and sets the registers to their reset values; the table memory
// is not cleared since only entries below the count are ever read.
module first_fit_heap_allocator_top
   import ffha_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
   localparam logic [33:0] HDR = 34'(HEADER_BYTES);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_MUL    = 10'b0000000010,
      S_RD     = 10'b0000000100,
      S_TEST   = 10'b0000001000,
      S_APPEND = 10'b0000010000,
      S_FRD    = 10'b0000100000,
      S_FTEST  = 10'b0001000000,
      S_REL    = 10'b0010000000,
      S_DONE   = 10'b0100000000,
      S_OREL   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] heap_limit_ff, break_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] found_ff, found_in;
   entry_type     found_ent_ff, found_ent_in;
   req_type       req_ff;
   logic [32:0]   want_ff, want_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   addr_ff, addr_in;
   logic          resize_ff, resize_in;

   // Table memory.
   entry_type mem [MAX_BLOCKS];
   entry_type rd_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Multiplier for zeroed allocate.
   logic        mul_start, mul_done;
   logic [63:0] mul_p;
   ffha_mul u_mul (
      .clock(clock), .start(mul_start), .op_a(req_ff.element_count),
      .op_b(req_ff.request_size), .product(mul_p), .done(mul_done)
   );

   // Output register.
   logic    out_valid_ff;
   rsp_type out_ff;
   logic    emit;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   logic accept;
   assign accept = req_valid && !req_stall;

   logic [33:0] hdr_addr_rd, end_rd, new_break;
   assign hdr_addr_rd = {2'd0, rd_ff.base} + HDR;
   assign end_rd      = hdr_addr_rd + {2'd0, rd_ff.size};
   assign new_break   = {2'd0, break_ff} + HDR + {1'd0, want_ff};

   logic scan_more;
   assign scan_more = scan_ff < count_ff;

   // Release target: last block at the break is dropped, else marked free.
   logic [33:0] rel_end;
   logic        rel_last;
   assign rel_end  = {2'd0, found_ent_ff.base} + HDR + {2'd0, found_ent_ff.size};
   assign rel_last = ({1'b0, found_ff} + 1'b1 == (IW+1)'(count_ff))
                     && (rel_end == {2'd0, break_ff});

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      found_ent_in = found_ent_ff;
      want_in      = want_ff;
      st_in        = st_ff;
      addr_in      = addr_ff;
      resize_in    = resize_ff;
      rd_addr      = scan_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = scan_ff[IW-1:0];
      wr_data      = rd_ff;
      mul_start    = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            scan_in   = '0;
            resize_in = 1'b0;
            st_in     = ST_OK;
            addr_in   = '0;
            want_in   = {1'b0, req_data.request_size};
            if (accept) begin
               case (req_data.mode)
                  MODE_ALLOC: begin
                     state_in = (req_data.request_size == 0) ? S_DONE : S_RD;
                     st_in    = (req_data.request_size == 0) ? ST_ZERO : ST_OK;
                  end
                  MODE_FREE: begin
                     state_in = (req_data.block_address == 0) ? S_DONE : S_FRD;
                  end
                  MODE_RESIZE: begin
                     if (req_data.block_address == 0 || req_data.request_size == 0) begin
                        state_in = (req_data.request_size == 0) ? S_DONE : S_RD;
                        st_in    = (req_data.request_size == 0) ? ST_ZERO : ST_OK;
                     end else begin
                        state_in = S_FRD;
                     end
                  end
                  default: begin
                     if (req_data.request_size == 0 || req_data.element_count == 0) begin
                        state_in = S_DONE;
                        st_in    = ST_ZERO;
                     end else begin
                        state_in = S_MUL;
                        scan_in  = '0;
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            mul_start = (scan_ff == 0);
            scan_in   = scan_ff + 1'b1;
            if (mul_done) begin
               scan_in = '0;
               if (mul_p[63:32] != 0) begin
                  st_in    = ST_OVERFLOW;
                  state_in = S_DONE;
               end else begin
                  want_in  = {1'b0, mul_p[31:0]};
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = scan_more ? S_TEST : S_APPEND;
         end
         S_TEST: begin
            if (rd_ff.free && ({1'b0, rd_ff.size} >= want_ff)) begin
               wr_en        = 1'b1;
               wr_data      = rd_ff;
               wr_data.free = 1'b0;
               addr_in      = hdr_addr_rd[31:0];
               state_in     = resize_ff ? S_OREL : S_DONE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_APPEND: begin
            if (count_ff >= MAX_CNT || new_break > {2'd0, heap_limit_ff}) begin
               st_in    = ST_NOSPACE;
               state_in = S_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               wr_data  = '{base: break_ff, size: want_ff[31:0], free: 1'b0};
               addr_in  = 32'(({2'd0, break_ff} + HDR));
               state_in = resize_ff ? S_OREL : S_DONE;
            end
         end
         S_FRD: begin
            state_in = S_FTEST;
            if (!scan_more) begin
               st_in    = ST_UNKNOWN;
               state_in = S_DONE;
            end
         end
         S_FTEST: begin
            if (!rd_ff.free && hdr_addr_rd[31:0] == req_ff.block_address) begin
               found_in     = scan_ff[IW-1:0];
               found_ent_in = rd_ff;
               if (req_ff.mode == MODE_FREE) begin
                  state_in = S_REL;
               end else if ({1'b0, rd_ff.size} >= want_ff) begin
                  addr_in  = req_ff.block_address;
                  state_in = S_DONE;
               end else begin
                  resize_in = 1'b1;
                  scan_in   = '0;
                  state_in  = S_RD;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_FRD;
            end
         end
         S_OREL: begin
            // New block placed for a resize; old block released next.
            state_in = S_REL;
         end
         S_REL: begin
            if (!rel_last) begin
               wr_en        = 1'b1;
               wr_addr      = found_ff;
               wr_data      = found_ent_ff;
               wr_data.free = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry count and break. Append bumps them; release of the tail drops them.
   logic append_ok;
   assign append_ok = (state_ff == S_APPEND) && (state_in != S_DONE || !resize_ff)
                      && !(count_ff >= MAX_CNT || new_break > {2'd0, heap_limit_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         break_ff      <= '0;
         heap_limit_ff <= 32'd65536;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAP_BASE: begin
                  // The heap base only matters as the break of an empty table.
                  if (count_ff == 0) begin
                     break_ff <= csr_wdata;
                  end
               end
               default: heap_limit_ff <= csr_wdata;
            endcase
         end
         if (append_ok) begin
            count_ff <= count_ff + 1'b1;
            break_ff <= new_break[31:0];
         end else if (state_ff == S_REL && rel_last) begin
            count_ff <= count_ff - 1'b1;
            break_ff <= found_ent_ff.base;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      found_ff     <= found_in;
      found_ent_ff <= found_ent_in;
      want_ff      <= want_in;
      st_ff        <= st_in;
      addr_ff      <= addr_in;
      resize_ff    <= resize_in;
      if (accept) begin
         req_ff <= req_data;
      end
      if (emit) begin
         out_ff.status  <= st_ff;
         out_ff.address <= (st_ff == ST_OK) ? addr_ff : 32'd0;
      end
   end

`ifndef SYNTHESIS
   // The table never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("entry count exceeds table depth");

   // A result is only loaded into the output register when it is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_valid_ff || !rsp_stall)) else $error("result overwritten");

   // A stalled result holds its value.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // Requests are only taken while idle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepted while busy");
`endif

endmodule

// File: sv/ffha_mul.sv
// Unsigned 32 by 32 product, formed from four 16 by 16 partial products
// in a register stage of partial products followed by a register stage
// for their sum. The product is valid while done is high; done follows start through the same registers.
module ffha_mul
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        start,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product,
   output logic        done
);

   logic [31:0] p_ll_ff, p_lh_ff, p_hl_ff, p_hh_ff;
   logic        stage_ff;
   logic [63:0] product_ff;
   logic        done_ff;

   // Partial products.
   always_ff @(posedge clock) begin
      p_ll_ff  <= op_a[15:0]  * op_b[15:0];
      p_lh_ff  <= op_a[15:0]  * op_b[31:16];
      p_hl_ff  <= op_a[31:16] * op_b[15:0];
      p_hh_ff  <= op_a[31:16] * op_b[31:16];
      stage_ff <= start;
   end

   // Sum of the shifted partial products.
   always_ff @(posedge clock) begin
      product_ff <= {p_hh_ff, 32'd0} + {16'd0, p_lh_ff, 16'd0}
                    + {16'd0, p_hl_ff, 16'd0} + {32'd0, p_ll_ff};
      done_ff    <= stage_ff;
   end

   assign product = product_ff;
   assign done    = done_ff;

endmodule
